// ===== rtl/core/retransmit_slot_tracker_macros.svh =====
// Assertion macros for the retransmit slot tracker checkers.
// Needs clk and arst_n to exist in the scope where a macro is used.
`ifndef RETRANSMIT_SLOT_TRACKER_MACROS_SVH
`define RETRANSMIT_SLOT_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define RSTK_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define RSTK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rstk_pkg.sv =====
// Shared types and constants of the retransmit slot tracker.
// No dependencies; imported by every module of the block except rstk_ram.
`timescale 1ns / 1ps
package rstk_pkg;

	localparam logic [1:0] CMD_SEND  = 2'd0;
	localparam logic [1:0] CMD_ACK   = 2'd1;
	localparam logic [1:0] CMD_OTHER = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	localparam logic [3:0] KIND_SENT      = 4'd0;
	localparam logic [3:0] KIND_FULL      = 4'd1;
	localparam logic [3:0] KIND_NOT_EST   = 4'd2;
	localparam logic [3:0] KIND_REDUNDANT = 4'd3;
	localparam logic [3:0] KIND_ACKED     = 4'd4;
	localparam logic [3:0] KIND_ACTIVITY  = 4'd5;
	localparam logic [3:0] KIND_RESEND    = 4'd6;
	localparam logic [3:0] KIND_HEARTBEAT = 4'd7;
	localparam logic [3:0] KIND_DEAD      = 4'd8;
	localparam logic [3:0] KIND_SCAN_DONE = 4'd9;

	localparam logic [1:0] REG_IS_SERVER = 2'd0;
	localparam logic [1:0] REG_LINK      = 2'd1;
	localparam logic [1:0] REG_DEAD      = 2'd2;
	localparam logic [1:0] REG_HEARTBEAT = 2'd3;

	localparam logic [31:0] DEAD_RESET      = 32'd3600000;
	localparam logic [31:0] HEARTBEAT_RESET = 32'd240000;
	localparam logic [31:0] RTT_RESET       = 32'd20;
	// ceil(2^37 / 5): exact floor division by five for any sum below 2^35.
	localparam logic [34:0] RECIP5_MUL      = 35'h6_6666_6667;
	localparam int          RECIP5_SH       = 37;
	localparam int          DIV_W           = 35;
	localparam int          TIME_W          = 48;

	// Source of the slot_index field of an item.
	typedef enum logic [1:0] {
		SLOT_ZERO,
		SLOT_IDX,
		SLOT_ACK
	} slot_sel_t;

	typedef struct packed {
		logic      latch;
		logic      idx_from_ptr;
		logic      idx_step;
		logic      alloc;
		logic      mod_start;
		logic      mod_rd;
		logic      sample_cap;
		logic      sum_start;
		logic      ack_fin;
		logic      gap_cap;
		logic      dead_clr;
		logic      scan_init;
		logic      scan_rd;
		logic      scan_wr;
		logic      emit;
		logic [3:0] kind;
		slot_sel_t slot_sel;
		logic      last;
	} rstk_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       link;
		logic       full;
		logic       idx_busy;
		logic       ack_busy;
		logic       div_busy;
		logic       dead_hit;
		logic       hb_hit;
		logic       scan_hit;
		logic       idx_last;
		logic       can_emit;
	} rstk_stat_t;

endpackage

// ===== rtl/core/retransmit_slot_tracker.sv =====
// A send that takes a slot walks the slots from the pointer to a free one; a tick that finds
// neither dead nor heartbeat scans every slot. One item in work at a time; the next is taken
// once the last result is registered, and a result waits on out_ready while the receiver stalls.
// Reset is asynchronous: config to defaults, slots free, RTT and minimum 20, pointer 0.
`timescale 1ns / 1ps
module retransmit_slot_tracker
	import rstk_pkg::*;
#(
	parameter int SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] ack_number,
	input  logic [47:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  result_kind,
	output logic [4:0]  slot_index,
	output logic [31:0] smoothed_rtt_ms,
	output logic [31:0] min_rtt_ms,
	output logic        last_result
);
	rstk_cmd_t  cmd;
	rstk_stat_t stat;

	rstk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rstk_dp #(.SLOTS(SLOTS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.command         (command),
		.ack_number      (ack_number),
		.now_ms          (now_ms),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.result_kind     (result_kind),
		.slot_index      (slot_index),
		.smoothed_rtt_ms (smoothed_rtt_ms),
		.min_rtt_ms      (min_rtt_ms),
		.last_result     (last_result),
		.cmd             (cmd),
		.stat            (stat)
	);
endmodule

// ===== rtl/core/rstk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rstk_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/core/rstk_ctrl.sv =====
// Controller state machine of the retransmit slot tracker.
// Depends on rstk_pkg; drives rstk_dp through command and status structs.
`timescale 1ns / 1ps
module rstk_ctrl
	import rstk_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  rstk_stat_t stat,
	output rstk_cmd_t  cmd
);
	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP,
		ST_S_CHK, ST_S_SCAN,
		ST_A_MOD, ST_A_MODW, ST_A_CHK, ST_A_SUM, ST_A_DIVW, ST_A_FIN, ST_A_EMIT,
		ST_O_EMIT,
		ST_T_GAP, ST_T_DEC, ST_T_RD, ST_T_CMP, ST_T_END
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.slot_sel = SLOT_ZERO;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				case (stat.cmd)
					CMD_SEND:  state_d = ST_S_CHK;
					CMD_ACK:   state_d = ST_A_MOD;
					CMD_OTHER: state_d = ST_O_EMIT;
					default:   state_d = ST_T_GAP;
				endcase
			end
			ST_S_CHK: begin
				if (!stat.link || stat.full) begin
					cmd.kind = stat.link ? KIND_FULL : KIND_NOT_EST;
					cmd.last = 1'b1;
					if (stat.can_emit) begin
						cmd.emit = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.idx_from_ptr = 1'b1;
					state_d = ST_S_SCAN;
				end
			end
			ST_S_SCAN: begin
				// A free slot exists, so this walk ends within one lap.
				if (stat.idx_busy) begin
					cmd.idx_step = 1'b1;
				end else if (stat.can_emit) begin
					cmd.alloc = 1'b1;
					cmd.emit = 1'b1;
					cmd.kind = KIND_SENT;
					cmd.slot_sel = SLOT_IDX;
					cmd.last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_A_MOD: begin
				cmd.mod_start = 1'b1;
				state_d = ST_A_MODW;
			end
			ST_A_MODW: begin
				if (!stat.div_busy) begin
					cmd.mod_rd = 1'b1;
					state_d = ST_A_CHK;
				end
			end
			ST_A_CHK: begin
				if (stat.ack_busy) begin
					cmd.sample_cap = 1'b1;
					state_d = ST_A_SUM;
				end else begin
					cmd.kind = KIND_REDUNDANT;
					cmd.last = 1'b1;
					if (stat.can_emit) begin
						cmd.emit = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_A_SUM: begin
				cmd.sum_start = 1'b1;
				state_d = ST_A_DIVW;
			end
			ST_A_DIVW: begin
				if (!stat.div_busy) begin
					state_d = ST_A_FIN;
				end
			end
			ST_A_FIN: begin
				cmd.ack_fin = 1'b1;
				state_d = ST_A_EMIT;
			end
			ST_A_EMIT: begin
				cmd.kind = KIND_ACKED;
				cmd.slot_sel = SLOT_ACK;
				cmd.last = 1'b1;
				if (stat.can_emit) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_O_EMIT: begin
				cmd.kind = KIND_ACTIVITY;
				cmd.last = 1'b1;
				if (stat.can_emit) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_T_GAP: begin
				cmd.gap_cap = 1'b1;
				state_d = ST_T_DEC;
			end
			ST_T_DEC: begin
				if (stat.dead_hit || stat.hb_hit) begin
					cmd.kind = stat.dead_hit ? KIND_DEAD :
						(stat.link ? KIND_HEARTBEAT : KIND_NOT_EST);
					cmd.last = 1'b1;
					if (stat.can_emit) begin
						cmd.emit = 1'b1;
						cmd.dead_clr = stat.dead_hit;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.scan_init = 1'b1;
					state_d = ST_T_RD;
				end
			end
			ST_T_RD: begin
				cmd.scan_rd = 1'b1;
				state_d = ST_T_CMP;
			end
			ST_T_CMP: begin
				cmd.kind = KIND_RESEND;
				cmd.slot_sel = SLOT_IDX;
				// An overdue slot on a live link holds here until its item can go out.
				if (!(stat.scan_hit && stat.link) || stat.can_emit) begin
					cmd.scan_wr = stat.scan_hit;
					cmd.emit = stat.scan_hit && stat.link;
					if (stat.idx_last) begin
						state_d = ST_T_END;
					end else begin
						cmd.idx_step = 1'b1;
						state_d = ST_T_RD;
					end
				end
			end
			ST_T_END: begin
				cmd.kind = KIND_SCAN_DONE;
				cmd.last = 1'b1;
				if (stat.can_emit) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== rtl/core/rstk_dp.sv =====
// Datapath of the retransmit slot tracker: registers, slot state, divider, output stage.
// Depends on rstk_pkg and rstk_ram; steered by rstk_ctrl.
`timescale 1ns / 1ps
module rstk_dp
	import rstk_pkg::*;
#(
	parameter int SLOTS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic [1:0]   command,
	input  logic [15:0]  ack_number,
	input  logic [47:0]  now_ms,
	input  logic         out_ready,
	output logic         out_valid,
	output logic [3:0]   result_kind,
	output logic [4:0]   slot_index,
	output logic [31:0]  smoothed_rtt_ms,
	output logic [31:0]  min_rtt_ms,
	output logic         last_result,
	input  rstk_cmd_t    cmd,
	output rstk_stat_t   stat
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SW-1:0] IDX_LAST = SW'(SLOTS - 1);
	// ceil(2^22 / SLOTS): exact quotient of any 16-bit ack number by SLOTS.
	localparam logic [21:0] MOD_MUL = 22'((2**22 + SLOTS - 1) / SLOTS);
	localparam logic [15:0] SLOTS16 = 16'(SLOTS);

	logic              is_server_q, link_q;
	logic [31:0]       dead_q, hb_q;
	logic [SLOTS-1:0]  busy_q;
	logic [SW:0]       cnt_q;
	logic [SW-1:0]     ptr_q, idx_q, ack_slot_q;
	logic [31:0]       rtt_q, rmin_q;
	logic [47:0]       last_act_q;
	logic [1:0]        cmd_q;
	logic [15:0]       ackn_q;
	logic [47:0]       now_q, gap_q;
	logic [31:0]       sample_q;
	logic [32:0]       step_q;

	logic [37:0]       mod_prod;
	logic [15:0]       mod_q_q, mod_rem;

	logic [DIV_W-1:0]  div_x_q;
	logic [17:0]       div_mul_b;
	logic [52:0]       div_pp, div_lo_q, div_hi_q;
	logic [69:0]       div_sum;
	logic [31:0]       div_quo_q;
	logic [1:0]        div_cnt_q;

	logic              out_valid_q, last_q;
	logic [3:0]        kind_q;
	logic [4:0]        slot_q;
	logic [31:0]       out_rtt_q, out_min_q;

	logic [47:0]       send_rdata, dl_rdata, dl_wdata, diff;
	logic              dl_we;
	logic [SW-1:0]     raddr;
	logic [SW-1:0]     idx_next;

	assign idx_next = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
	assign raddr    = cmd.mod_rd ? mod_rem[SW-1:0] : idx_q;
	assign dl_we    = cmd.alloc || cmd.scan_wr;
	assign dl_wdata = cmd.alloc ? now_q + 48'(rtt_q) : dl_rdata + 48'(step_q);
	assign diff     = now_q - send_rdata;

	// Slot of an ack: quotient by reciprocal multiplication, then one multiply-subtract.
	assign mod_prod = 38'(ackn_q) * 38'(MOD_MUL);
	assign mod_rem  = ackn_q - mod_q_q * SLOTS16;

	// The sum is divided by five with one shared multiplier, low then high half of the
	// reciprocal, and the two registered partial products are then added for the quotient.
	assign div_mul_b = (div_cnt_q == 2'd3) ? RECIP5_MUL[17:0] : {1'b0, RECIP5_MUL[34:18]};
	assign div_pp    = 53'(div_x_q) * 53'(div_mul_b);
	assign div_sum   = {div_hi_q[51:0], 18'd0} + 70'(div_lo_q);

	rstk_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_send_ram (
		.clk   (clk),
		.we    (cmd.alloc),
		.waddr (idx_q),
		.wdata (now_q),
		.re    (cmd.mod_rd),
		.raddr (raddr),
		.rdata (send_rdata)
	);

	rstk_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_dl_ram (
		.clk   (clk),
		.we    (dl_we),
		.waddr (idx_q),
		.wdata (dl_wdata),
		.re    (cmd.scan_rd),
		.raddr (raddr),
		.rdata (dl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_server_q <= 1'b1;
			link_q      <= 1'b0;
			dead_q      <= DEAD_RESET;
			hb_q        <= HEARTBEAT_RESET;
			busy_q      <= '0;
			cnt_q       <= '0;
			ptr_q       <= '0;
			rtt_q       <= RTT_RESET;
			rmin_q      <= RTT_RESET;
			last_act_q  <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IS_SERVER: is_server_q <= cfg_data[0];
					REG_LINK:      link_q      <= cfg_data[0];
					REG_DEAD:      dead_q      <= cfg_data;
					REG_HEARTBEAT: hb_q        <= cfg_data;
					default:       is_server_q <= is_server_q;
				endcase
			end
			if (cmd.latch && (command == CMD_ACK || command == CMD_OTHER)) begin
				last_act_q <= now_ms;
			end
			if (cmd.alloc) begin
				busy_q[idx_q] <= 1'b1;
				cnt_q         <= cnt_q + 1'b1;
				ptr_q         <= idx_next;
			end
			if (cmd.ack_fin) begin
				rtt_q <= div_quo_q;
				if (div_quo_q < rmin_q) begin
					rmin_q <= div_quo_q;
				end
				busy_q[ack_slot_q] <= 1'b0;
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (cmd.dead_clr) begin
				busy_q <= '0;
				cnt_q  <= '0;
			end
			if (cmd.sum_start) begin
				div_cnt_q <= 2'd3;
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q  <= command;
			ackn_q <= ack_number;
			now_q  <= now_ms;
		end
		if (cmd.idx_from_ptr) begin
			idx_q <= ptr_q;
		end else if (cmd.scan_init) begin
			idx_q <= '0;
		end else if (cmd.idx_step) begin
			idx_q <= idx_next;
		end
		if (cmd.scan_init) begin
			step_q <= 33'(rtt_q) + 33'(rtt_q >> 1);
		end
		if (cmd.gap_cap) begin
			gap_q <= (now_q > last_act_q) ? now_q - last_act_q : '0;
		end
		if (cmd.mod_start) begin
			mod_q_q <= mod_prod[37:22];
		end
		if (cmd.mod_rd) begin
			ack_slot_q <= mod_rem[SW-1:0];
		end
		if (cmd.sample_cap) begin
			if (now_q <= send_rdata) begin
				sample_q <= 32'd1;
			end else if (diff[47:32] != '0) begin
				sample_q <= '1;
			end else begin
				sample_q <= diff[31:0];
			end
		end
		if (cmd.sum_start) begin
			div_x_q <= DIV_W'({rtt_q, 2'b00}) + DIV_W'(sample_q);
		end
		if (div_cnt_q == 2'd3) begin
			div_lo_q <= div_pp;
		end
		if (div_cnt_q == 2'd2) begin
			div_hi_q <= div_pp;
		end
		if (div_cnt_q == 2'd1) begin
			div_quo_q <= div_sum[RECIP5_SH+31:RECIP5_SH];
		end
		if (cmd.emit) begin
			kind_q    <= cmd.kind;
			last_q    <= cmd.last;
			out_rtt_q <= rtt_q;
			out_min_q <= rmin_q;
			case (cmd.slot_sel)
				SLOT_IDX: slot_q <= 5'(idx_q);
				SLOT_ACK: slot_q <= 5'(ack_slot_q);
				default:  slot_q <= '0;
			endcase
		end
	end

	assign stat.cmd      = cmd_q;
	assign stat.link     = link_q;
	assign stat.full     = (cnt_q >= (SW+1)'(SLOTS));
	assign stat.idx_busy = busy_q[idx_q];
	assign stat.ack_busy = busy_q[ack_slot_q];
	assign stat.div_busy = (div_cnt_q != '0);
	assign stat.dead_hit = is_server_q && (gap_q >= 48'(dead_q));
	assign stat.hb_hit   = is_server_q && (gap_q > 48'(hb_q));
	assign stat.scan_hit = busy_q[idx_q] && (dl_rdata <= now_q);
	assign stat.idx_last = (idx_q == IDX_LAST);
	assign stat.can_emit = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign result_kind     = kind_q;
	assign slot_index      = slot_q;
	assign smoothed_rtt_ms = out_rtt_q;
	assign min_rtt_ms      = out_min_q;
	assign last_result     = last_q;
endmodule

// ===== rtl/core/rstk_chk.sv =====
// Port-level checker for the retransmit slot tracker, bound to the top level.
// Depends on rstk_pkg and retransmit_slot_tracker_macros.svh.
`timescale 1ns / 1ps
`include "retransmit_slot_tracker_macros.svh"
module rstk_chk
	import rstk_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  result_kind,
	input logic [4:0]  slot_index,
	input logic        last_result
);
	`RSTK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_kind), "result item changed while stalled")
	`RSTK_ASSERT_NOW(a_resend_not_last, out_valid && (result_kind == KIND_RESEND), !last_result, "resend item marked last")
	`RSTK_ASSERT_NOW(a_other_last, out_valid && (result_kind != KIND_RESEND), last_result, "closing item not marked last")
	`RSTK_ASSERT_NOW(a_slot_zero, out_valid && (result_kind != KIND_SENT) && (result_kind != KIND_ACKED) && (result_kind != KIND_RESEND), slot_index == 5'd0, "slot index set on slotless item")
	`RSTK_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while one is in work")
endmodule

bind retransmit_slot_tracker rstk_chk u_rstk_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.result_kind (result_kind),
	.slot_index  (slot_index),
	.last_result (last_result)
);

// ===== sim/retransmit_slot_tracker_tb.sv =====
// Self-checking testbench for retransmit_slot_tracker: directed table, then random phases.
// Depends on rstk_pkg and the tracker RTL; results are checked against an in-bench predictor.
`timescale 1ns / 1ps
module retransmit_slot_tracker_tb;
	import rstk_pkg::*;

	localparam logic [3:0] KIND_ANY = 4'hF;
	localparam int N_SLOTS = 32;

	typedef struct packed {
		logic [3:0]  kind;
		logic [4:0]  slot;
		logic [31:0] rtt;
		logic [31:0] rmin;
		logic        last;
	} outcome_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t   row;
		logic [1:0]  cmd;
		logic [15:0] ackn;
		logic [47:0] stamp;
		logic [3:0]  typed;
		logic [1:0]  reg_idx;
		logic [31:0] reg_val;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [15:0] ack_number;
	logic [47:0] now_ms;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  result_kind;
	logic [4:0]  slot_index;
	logic [31:0] smoothed_rtt_ms;
	logic [31:0] min_rtt_ms;
	logic        last_result;

	retransmit_slot_tracker #(.SLOTS(N_SLOTS)) dut (.*);

	always #10 clk = ~clk;

	// Tracker model state.
	logic        m_server, m_link;
	logic [31:0] m_dead_after, m_hb_after;
	logic        m_busy [N_SLOTS];
	logic [47:0] m_sent_at [N_SLOTS];
	logic [47:0] m_due_at [N_SLOTS];
	logic [31:0] m_rtt, m_rtt_min;
	logic [4:0]  m_ptr;
	int          m_nbusy;
	logic [47:0] m_last_seen;

	outcome_t pending_results[$];
	logic [3:0] cur_typed;
	bit failed = 0;
	bit calm = 0;
	int stall_token = 0;
	row_t table_rows[$];

	task automatic push_result(input logic [3:0] kind, input logic [4:0] slot, input logic last);
		outcome_t o;
		o.kind = kind;
		o.slot = slot;
		o.rtt = m_rtt;
		o.rmin = m_rtt_min;
		o.last = last;
		pending_results.push_back(o);
	endtask

	task automatic track_item(input logic [1:0] cmd, input logic [15:0] ackn,
			input logic [47:0] t);
		logic [4:0]  p;
		logic [63:0] sample, sum;
		logic [47:0] gap, stride;
		bit          placed;
		placed = 0;
		case (cmd)
			CMD_SEND: begin
				if (!m_link) push_result(KIND_NOT_EST, 5'd0, 1'b1);
				else if (m_nbusy >= N_SLOTS) push_result(KIND_FULL, 5'd0, 1'b1);
				else begin
					p = m_ptr;
					for (int i = 0; i < N_SLOTS && !placed; i++) begin
						if (!m_busy[p]) begin
							m_busy[p] = 1'b1;
							m_sent_at[p] = t;
							m_due_at[p] = t + {16'd0, m_rtt};
							m_nbusy++;
							m_ptr = p + 5'd1;
							push_result(KIND_SENT, p, 1'b1);
							placed = 1;
						end
						p = p + 5'd1;
					end
					if (!placed) push_result(KIND_FULL, 5'd0, 1'b1);
				end
			end
			CMD_ACK: begin
				p = ackn[4:0];
				m_last_seen = t;
				if (!m_busy[p]) push_result(KIND_REDUNDANT, 5'd0, 1'b1);
				else begin
					sample = (t > m_sent_at[p]) ? {16'd0, t - m_sent_at[p]} : 64'd0;
					if (sample == 0) sample = 1;
					if (sample > 64'hFFFF_FFFF) sample = 64'hFFFF_FFFF;
					sum = 4 * {32'd0, m_rtt} + sample;
					m_rtt = 32'(sum / 5);
					if (m_rtt < m_rtt_min) m_rtt_min = m_rtt;
					m_busy[p] = 1'b0;
					if (m_nbusy > 0) m_nbusy--;
					push_result(KIND_ACKED, p, 1'b1);
				end
			end
			CMD_OTHER: begin
				m_last_seen = t;
				push_result(KIND_ACTIVITY, 5'd0, 1'b1);
			end
			default: begin
				gap = (t > m_last_seen) ? t - m_last_seen : 48'd0;
				if (m_server && gap >= {16'd0, m_dead_after}) begin
					for (int i = 0; i < N_SLOTS; i++) m_busy[i] = 1'b0;
					m_nbusy = 0;
					push_result(KIND_DEAD, 5'd0, 1'b1);
				end else if (m_server && gap > {16'd0, m_hb_after}) begin
					push_result(m_link ? KIND_HEARTBEAT : KIND_NOT_EST, 5'd0, 1'b1);
				end else begin
					for (int i = 0; i < N_SLOTS; i++) begin
						if (m_busy[i] && m_due_at[i] <= t) begin
							stride = {16'd0, m_rtt} + {17'd0, m_rtt[31:1]};
							m_due_at[i] = m_due_at[i] + stride;
							if (m_link) push_result(KIND_RESEND, 5'(i), 1'b0);
						end
					end
					push_result(KIND_SCAN_DONE, 5'd0, 1'b1);
				end
			end
		endcase
	endtask

	// Input acceptance, register writes and result checking, all sampled at the edge.
	always @(posedge clk) begin
		int n0;
		outcome_t e;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IS_SERVER: m_server <= cfg_data[0];
					REG_LINK:      m_link <= cfg_data[0];
					REG_DEAD:      m_dead_after <= cfg_data;
					REG_HEARTBEAT: m_hb_after <= cfg_data;
					default:       m_server <= m_server;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result kind %0d", $time, result_kind);
					failed = 1;
				end else begin
					e = pending_results.pop_front();
					if (e.kind !== result_kind || e.slot !== slot_index ||
							e.rtt !== smoothed_rtt_ms || e.rmin !== min_rtt_ms ||
							e.last !== last_result) begin
						$display("%0t: mismatch expected kind %0d slot %0d rtt %0d min %0d last %0d",
							$time, e.kind, e.slot, e.rtt, e.rmin, e.last);
						$display("%0t:          actual kind %0d slot %0d rtt %0d min %0d last %0d",
							$time, result_kind, slot_index, smoothed_rtt_ms, min_rtt_ms,
							last_result);
						failed = 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				n0 = pending_results.size();
				track_item(command, ack_number, now_ms);
				if (cur_typed != KIND_ANY) pending_results[n0].kind = cur_typed;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver: random back-pressure plus one long hold-off on request.
	initial begin
		int seen, n;
		seen = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_token != seen) begin
				seen = stall_token;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			n = pick_gap();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic put_item(input logic [1:0] cmd, input logic [15:0] ackn,
			input logic [47:0] t, input logic [3:0] typed);
		int n;
		n = pick_gap();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		ack_number <= ackn;
		now_ms <= t;
		cur_typed <= typed;
		forever begin
			@(posedge clk);
			if (in_ready) break;
		end
	endtask

	// The first edge lets the predictor take in the item accepted at the current edge.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_item(input logic [1:0] cmd, input logic [15:0] ackn,
			input logic [47:0] t, input logic [3:0] typed);
		table_rows.push_back('{ROW_ITEM, cmd, ackn, t, typed, 2'd0, 32'd0});
	endtask

	task automatic add_reg(input logic [1:0] idx, input logic [31:0] val);
		table_rows.push_back('{ROW_REG, 2'd0, 16'd0, 48'd0, KIND_ANY, idx, val});
	endtask

	initial begin
		logic [47:0] t;
		logic [15:0] ackn;
		logic [1:0]  cmd;
		logic        srv, lnk;
		logic [31:0] dead_v, hb_v;
		int r, sel, send_w;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 2'd0;
		cfg_data = 32'd0;
		in_valid = 1'b0;
		command = 2'd0;
		ack_number = 16'd0;
		now_ms = 48'd0;
		cur_typed = KIND_ANY;
		m_server = 1'b1;
		m_link = 1'b0;
		m_dead_after = DEAD_RESET;
		m_hb_after = HEARTBEAT_RESET;
		for (int i = 0; i < N_SLOTS; i++) begin
			m_busy[i] = 1'b0;
			m_sent_at[i] = 48'd0;
			m_due_at[i] = 48'd0;
		end
		m_rtt = RTT_RESET;
		m_rtt_min = RTT_RESET;
		m_ptr = 5'd0;
		m_nbusy = 0;
		m_last_seen = 48'd0;

		// Directed part: defaults after reset, thresholds, saturation and wrap.
		add_item(CMD_SEND, 16'd0, 48'd0, KIND_NOT_EST);
		add_item(CMD_OTHER, 16'd0, 48'd5, KIND_ACTIVITY);
		add_item(CMD_ACK, 16'hFFFF, 48'd10, KIND_REDUNDANT);
		add_item(CMD_TICK, 16'd0, 48'd10, KIND_SCAN_DONE);
		add_item(CMD_TICK, 16'd0, 48'd240011, KIND_NOT_EST);
		add_reg(REG_LINK, 32'd1);
		add_item(CMD_TICK, 16'd0, 48'd240011, KIND_HEARTBEAT);
		add_item(CMD_TICK, 16'd0, 48'd3600010, KIND_DEAD);
		add_item(CMD_OTHER, 16'd0, 48'd3600010, KIND_ACTIVITY);
		add_item(CMD_SEND, 16'd0, 48'd3600010, KIND_ANY);
		add_item(CMD_SEND, 16'd0, 48'd3600011, KIND_ANY);
		add_item(CMD_TICK, 16'd0, 48'd3600030, KIND_ANY);
		// Ack that arrives before its send time counts as one millisecond.
		add_item(CMD_ACK, 16'd0, 48'd3600000, KIND_ANY);
		// A sample beyond 32 bits saturates.
		add_item(CMD_ACK, 16'd33, 48'hFFFF_FFFF_FFFF, KIND_ANY);
		add_item(CMD_OTHER, 16'd0, 48'd3600100, KIND_ACTIVITY);
		add_reg(REG_IS_SERVER, 32'd0);
		add_item(CMD_SEND, 16'd0, 48'hFFFF_FFFF_FFF0, KIND_ANY);
		add_item(CMD_TICK, 16'd0, 48'hFFFF_FFFF_FFFF, KIND_ANY);
		add_reg(REG_DEAD, 32'hFFFF_FFFF);
		add_reg(REG_HEARTBEAT, 32'd0);
		add_reg(REG_IS_SERVER, 32'd1);
		add_item(CMD_TICK, 16'd0, 48'd3600101, KIND_HEARTBEAT);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i]) begin
			if (table_rows[i].row == ROW_REG) begin
				drain();
				write_reg(table_rows[i].reg_idx, table_rows[i].reg_val);
			end else begin
				put_item(table_rows[i].cmd, table_rows[i].ackn, table_rows[i].stamp,
					table_rows[i].typed);
			end
		end

		// Random phases; each starts from an idle block with a fresh register setting.
		t = 48'd4000000;
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0: begin srv = 1; lnk = 1; dead_v = 32'hFFFF_FFFF; hb_v = 32'hFFFF_FFFF; end
				1: begin srv = 1; lnk = 1; dead_v = 32'd3000; hb_v = 32'd400; end
				2: begin srv = 0; lnk = 1; dead_v = 32'd1; hb_v = 32'd0; end
				3: begin srv = 1; lnk = 0; dead_v = 32'd5000; hb_v = 32'd200; end
				4: begin srv = 1; lnk = 1; dead_v = 32'd1; hb_v = 32'd0; end
				default: begin
					srv = $urandom_range(0, 1);
					lnk = ($urandom_range(0, 3) != 0);
					dead_v = $urandom_range(500, 20000);
					hb_v = $urandom_range(0, 600);
				end
			endcase
			calm = (ph == 1);
			write_reg(REG_IS_SERVER, {31'd0, srv});
			write_reg(REG_LINK, {31'd0, lnk});
			write_reg(REG_DEAD, dead_v);
			write_reg(REG_HEARTBEAT, hb_v);
			// The first phase leans on sends so that every slot fills up.
			send_w = (ph == 0) ? 65 : 35;
			for (int k = 0; k < 56; k++) begin
				if (ph == 0 && k == 20) stall_token++;
				r = $urandom_range(0, 99);
				if (r < 90) t = t + $urandom_range(0, 25);
				else t = t + $urandom_range(100, 5000);
				r = $urandom_range(0, 99);
				if (r < send_w) cmd = CMD_SEND;
				else if (r < send_w + 30) cmd = CMD_ACK;
				else if (r < send_w + 38) cmd = CMD_OTHER;
				else cmd = CMD_TICK;
				ackn = 16'($urandom_range(0, 65535));
				if (cmd == CMD_ACK && m_nbusy > 0 && $urandom_range(0, 99) < 85) begin
					sel = $urandom_range(0, N_SLOTS - 1);
					while (!m_busy[sel]) sel = (sel + 1) % N_SLOTS;
					ackn = {11'($urandom_range(0, 2047)), 5'(sel)};
				end
				if ($urandom_range(0, 99) < 3)
					put_item(cmd, ackn, t - $urandom_range(0, 50), KIND_ANY);
				else
					put_item(cmd, ackn, t, KIND_ANY);
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (!failed) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
